// ===== src/pesm_pkg.sv =====
// Shared types and constants of the per-id position smoother.
package pesm_pkg;

  localparam int ID_W       = 10;
  localparam int POS_W      = 32;
  localparam int ALPHA_W    = 17;
  localparam int THR_W      = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = POS_W;
  localparam int ACC_W      = 2 * MUL_W + 3;
  localparam int FRAC_W     = 16;
  localparam int AXES       = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;
  localparam logic [THR_W-1:0]   THR_RESET   = 31'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 4'd1;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_NEG   = 3'd1;
  localparam logic [2:0] DIST_LAST  = 3'd5;
  localparam logic [2:0] BLEND_LAST = 3'd7;

  typedef enum logic [1:0] {
    KIND_AVG    = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_REINIT = 2'd2
  } upd_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_Q,
    S_SLOT_R,
    S_READ,
    S_DIST,
    S_BLEND,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_RND,
    ACC_NEG,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic [ID_W-1:0]         obj_id;
    logic signed [POS_W-1:0] raw_x;
    logic signed [POS_W-1:0] raw_y;
    logic signed [POS_W-1:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]         out_id;
    logic signed [POS_W-1:0] smooth_x;
    logic signed [POS_W-1:0] smooth_y;
    logic signed [POS_W-1:0] smooth_z;
    upd_kind_t               update_kind;
  } out_item_t;

endpackage

// ===== src/per_id_ema_smoother_with_reinit.sv =====
// Top level of the per-id exponential position smoother with jump reinitialization.
//
// Each input beat carries an object id and a signed Q16.16 position; each one
// gives exactly one output beat with the id, the updated smoothed position and
// the kind of update. A beat is taken when valid is high and stall is low.
// The configuration channel writes alpha (index 0) and the reinit threshold
// (index 1); cfg_ready is always high and writes are meant for idle periods.
// One multiplier with an accumulator does the distance and blend arithmetic
// under a sequencer, so in_stall is high while an item is being worked on. A
// first sighting is written after the seen lookup, a reinitialization after
// the distance pass and an averaged update after the distance and blend passes;
// the next beat can be taken in the cycle after the result is registered. The
// multiplier sets the item rate: ten products per averaged item in sequence.
// After reset the seen flags are cleared by a pass over all ID_COUNT slots,
// during which in_stall is high. A stalled result waits in the output register;
// the sequencer then holds its finished item until that register frees up.
module per_id_ema_smoother_with_reinit import pesm_pkg::*; #(
  parameter int ID_COUNT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_payload,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_payload,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W   = $clog2(ID_COUNT);
  localparam int ID_SPAN  = 1 << ID_W;
  localparam int RECIP_SH = 2 * ID_W;
  localparam int RECIP    = (ID_COUNT < ID_SPAN) ? (1 << RECIP_SH) / ID_COUNT : 1;
  localparam int MOD_N    = (ID_COUNT < ID_SPAN) ? ID_COUNT : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ID_COUNT - 1);

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ALPHA_W-1:0] alpha_r;
  logic [THR_W-1:0] thr_r;
  logic out_valid_r;
  out_item_t out_payload_r;

  logic [ID_W-1:0] id_r;
  logic [AXES-1:0][POS_W-1:0] raw_b_r;
  logic [AXES-1:0][POS_W-1:0] new_r;
  upd_kind_t kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_calc;
  logic [ID_W-1:0] rem;

  logic in_fire, out_fire, out_free, jump, seen;
  logic [1:0] axis_sel;
  logic [POS_W-1:0] sel_raw, sel_old, d_abs;
  logic [ALPHA_W-1:0] w_eff, w_inv;
  logic [MUL_W-1:0] mul_a, mul_b;
  acc_op_t acc_op;
  logic [ACC_W-1:0] acc;

  logic seen_wr_en, seen_wr_data, pos_wr_en, rd_en;
  logic [SLOT_W-1:0] seen_wr_addr;
  logic [0:0] seen_rd;
  logic [AXES*POS_W-1:0] pos_rd;
  logic [AXES-1:0][POS_W-1:0] old_b;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign seen     = seen_rd[0];
  assign old_b    = pos_rd;
  assign jump     = !acc[ACC_W-1] && (acc != '0);
  assign w_eff    = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign w_inv    = ALPHA_ONE - w_eff;

  if (ID_COUNT < ID_SPAN) begin : g_mod
    logic [ID_W-1:0]   q_r;
    logic [2*ID_W-1:0] qn;
    logic [ID_W-1:0]   diff;
    always_ff @(posedge clk) begin
      q_r <= ID_W'(((RECIP_SH + ID_W)'(id_r) * (RECIP_SH + ID_W)'(RECIP)) >> RECIP_SH);
    end
    assign qn   = (2*ID_W)'(q_r) * (2*ID_W)'(MOD_N);
    assign diff = id_r - qn[ID_W-1:0];
    assign rem  = (diff >= ID_W'(MOD_N)) ? diff - ID_W'(MOD_N) : diff;
  end else begin : g_wide
    assign rem = id_r;
  end

  if (SLOT_W <= ID_W) begin : g_slot_narrow
    assign slot_calc = rem[SLOT_W-1:0];
  end else begin : g_slot_wide
    assign slot_calc = {{(SLOT_W - ID_W){1'b0}}, rem};
  end

  always_comb begin
    case (state_r)
      S_DIST:  axis_sel = 2'(step_r - STEP_NEG);
      S_BLEND: axis_sel = step_r[2:1];
      default: axis_sel = 2'd0;
    endcase
  end

  always_comb begin
    case (axis_sel)
      2'd0: begin
        sel_raw = raw_b_r[0];
        sel_old = old_b[0];
      end
      2'd1: begin
        sel_raw = raw_b_r[1];
        sel_old = old_b[1];
      end
      2'd2: begin
        sel_raw = raw_b_r[2];
        sel_old = old_b[2];
      end
      default: begin
        sel_raw = '0;
        sel_old = '0;
      end
    endcase
  end

  assign d_abs = (sel_raw > sel_old) ? sel_raw - sel_old : sel_old - sel_raw;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SLOT_Q;
        end
      end
      S_SLOT_Q: state_nxt = S_SLOT_R;
      S_SLOT_R: state_nxt = S_READ;
      S_READ: begin
        state_nxt = S_DIST;
        step_nxt  = STEP_FIRST;
      end
      S_DIST: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_FIRST && !seen) begin
          state_nxt = S_WRITE;
        end else if (step_r == DIST_LAST) begin
          step_nxt  = STEP_FIRST;
          state_nxt = jump ? S_WRITE : S_BLEND;
        end
      end
      S_BLEND: begin
        step_nxt = step_r + 1'b1;
        if (step_r == BLEND_LAST) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    mul_a        = '0;
    mul_b        = '0;
    acc_op       = ACC_HOLD;
    rd_en        = 1'b0;
    pos_wr_en    = 1'b0;
    seen_wr_en   = 1'b0;
    seen_wr_addr = slot_r;
    seen_wr_data = 1'b1;
    case (state_r)
      S_CLEAR: begin
        seen_wr_en   = 1'b1;
        seen_wr_addr = clr_cnt_r;
        seen_wr_data = 1'b0;
      end
      S_IDLE: in_stall = 1'b0;
      S_READ: rd_en = 1'b1;
      S_DIST: begin
        if (step_r == STEP_FIRST) begin
          mul_a = MUL_W'(thr_r);
          mul_b = MUL_W'(thr_r);
        end else begin
          mul_a = d_abs;
          mul_b = d_abs;
        end
        if (step_r == STEP_NEG) begin
          acc_op = ACC_NEG;
        end else if (step_r != STEP_FIRST && step_r != DIST_LAST) begin
          acc_op = ACC_ADD;
        end
      end
      S_BLEND: begin
        if (step_r[0]) begin
          mul_a  = MUL_W'(w_inv);
          mul_b  = sel_old;
          acc_op = ACC_LOAD_RND;
        end else begin
          mul_a  = MUL_W'(w_eff);
          mul_b  = sel_raw;
          acc_op = (step_r == STEP_FIRST) ? ACC_HOLD : ACC_ADD;
        end
      end
      S_WRITE: begin
        pos_wr_en  = out_free;
        seen_wr_en = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= STEP_FIRST;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RESET;
      thr_r       <= THR_RESET;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (state_r == S_WRITE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ALPHA) begin
          alpha_r <= cfg_data[ALPHA_W-1:0];
        end else if (cfg_index == CFG_THRESH) begin
          thr_r <= cfg_data[THR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r       <= in_payload.obj_id;
      raw_b_r[0] <= {~in_payload.raw_x[POS_W-1], in_payload.raw_x[POS_W-2:0]};
      raw_b_r[1] <= {~in_payload.raw_y[POS_W-1], in_payload.raw_y[POS_W-2:0]};
      raw_b_r[2] <= {~in_payload.raw_z[POS_W-1], in_payload.raw_z[POS_W-2:0]};
    end
    if (state_r == S_SLOT_R) begin
      slot_r <= slot_calc;
    end
    if (state_r == S_DIST) begin
      if (step_r == STEP_FIRST && !seen) begin
        new_r  <= raw_b_r;
        kind_r <= KIND_FIRST;
      end else if (step_r == DIST_LAST && jump) begin
        new_r  <= raw_b_r;
        kind_r <= KIND_REINIT;
      end
    end
    if (state_r == S_BLEND) begin
      kind_r <= KIND_AVG;
      if (step_r[0] && step_r != STEP_NEG) begin
        new_r[2'(step_r[2:1] - 2'd1)] <= acc[FRAC_W +: POS_W];
      end
    end
    if (state_r == S_WRITE && out_free) begin
      out_payload_r.out_id      <= id_r;
      out_payload_r.smooth_x    <= signed'({~new_r[0][POS_W-1], new_r[0][POS_W-2:0]});
      out_payload_r.smooth_y    <= signed'({~new_r[1][POS_W-1], new_r[1][POS_W-2:0]});
      out_payload_r.smooth_z    <= signed'({~new_r[2][POS_W-1], new_r[2][POS_W-2:0]});
      out_payload_r.update_kind <= kind_r;
    end
  end

  pesm_mac u_mac (
    .clk    (clk),
    .acc_op (acc_op),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .acc    (acc)
  );

  pesm_ram #(
    .WIDTH (1),
    .DEPTH (ID_COUNT)
  ) u_seen_ram (
    .clk     (clk),
    .wr_en   (seen_wr_en),
    .wr_addr (seen_wr_addr),
    .wr_data (seen_wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd_data (seen_rd)
  );

  pesm_ram #(
    .WIDTH (AXES * POS_W),
    .DEPTH (ID_COUNT)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_wr_en),
    .wr_addr (slot_r),
    .wr_data (new_r),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd_data (pos_rd)
  );

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign cfg_ready   = 1'b1;

endmodule

// ===== src/pesm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pesm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pesm_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulator.
module pesm_mac import pesm_pkg::*; (
  input  logic             clk,
  input  acc_op_t          acc_op,
  input  logic [MUL_W-1:0] op_a,
  input  logic [MUL_W-1:0] op_b,
  output logic [ACC_W-1:0] acc
);

  logic [2*MUL_W-1:0] prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [ACC_W-1:0]   prod_ext;

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    case (acc_op)
      ACC_HOLD:     acc_nxt = acc_r;
      ACC_LOAD_RND: acc_nxt = prod_ext + ACC_W'(ALPHA_ONE >> 1);
      ACC_NEG:      acc_nxt = '0 - prod_ext;
      ACC_ADD:      acc_nxt = acc_r + prod_ext;
      default:      acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== src/pesm_chk.sv =====
// Port-level checker for the per-id position smoother, bound to the top level.
module pesm_chk import pesm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_payload
);

  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("Input is not stalled after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second beat could be taken right after an accepted beat.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("A result appeared too soon after an accepted beat.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("A stalled output beat changed or dropped.");

endmodule

bind per_id_ema_smoother_with_reinit pesm_chk u_pesm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);
